/* design/rhcc_pkg.sv */
`default_nettype none

package rhcc_pkg;

   // Sample width
   localparam int CHANNEL_BITS = 10;

   // Result field widths
   localparam int HUE_BITS   = 9;
   localparam int FIELD_BITS = 10;
   localparam int CODE_BITS  = 3;

   // Comparisons run at the wider of channel and register width
   localparam int CMP_BITS = (CHANNEL_BITS > FIELD_BITS) ? CHANNEL_BITS : FIELD_BITS;

   // Divider: the quotient never exceeds 60, so six steps suffice
   localparam int QUO_BITS   = 6;
   localparam int NUM_BITS   = CHANNEL_BITS + QUO_BITS;
   localparam int CNT_BITS   = 3;
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(QUO_BITS - 1);

   // Hue arithmetic width and sector constants
   localparam int HUE_EXT_BITS = HUE_BITS + 1;
   localparam logic [HUE_EXT_BITS-1:0] HUE_FULL_TURN  = HUE_EXT_BITS'(360);
   localparam logic [HUE_EXT_BITS-1:0] HUE_GREEN_BASE = HUE_EXT_BITS'(120);
   localparam logic [HUE_EXT_BITS-1:0] HUE_BLUE_BASE  = HUE_EXT_BITS'(240);

   // Control register file
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_RED_YELLOW    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_YELLOW_GREEN  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_GREEN_BLUE    = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_BLUE_RED      = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SAT_CHROMATIC = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SAT_YELLOW    = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRAY_SAT_LIMIT    = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLACK_WHITE_SPLIT = 4'd7;

   localparam logic [HUE_BITS-1:0]   RST_HUE_RED_YELLOW    = 9'd30;
   localparam logic [HUE_BITS-1:0]   RST_HUE_YELLOW_GREEN  = 9'd90;
   localparam logic [HUE_BITS-1:0]   RST_HUE_GREEN_BLUE    = 9'd150;
   localparam logic [HUE_BITS-1:0]   RST_HUE_BLUE_RED      = 9'd270;
   localparam logic [FIELD_BITS-1:0] RST_MIN_SAT_CHROMATIC = 10'd20;
   localparam logic [FIELD_BITS-1:0] RST_MIN_SAT_YELLOW    = 10'd50;
   localparam logic [FIELD_BITS-1:0] RST_GRAY_SAT_LIMIT    = 10'd50;
   localparam logic [FIELD_BITS-1:0] RST_BLACK_WHITE_SPLIT = 10'd100;

   typedef enum logic [CODE_BITS-1:0] {
      CLS_NONE   = 3'd0,
      CLS_BLACK  = 3'd1,
      CLS_WHITE  = 3'd2,
      CLS_RED    = 3'd3,
      CLS_YELLOW = 3'd4,
      CLS_GREEN  = 3'd5,
      CLS_BLUE   = 3'd6
   } color_code_type;

   typedef enum logic [1:0] {
      SEL_RED   = 2'd0,
      SEL_GREEN = 2'd1,
      SEL_BLUE  = 2'd2
   } max_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SETUP  = 2'd1,
      ST_DIV    = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

endpackage

`default_nettype wire

/* design/rgb_hsv_color_classifier_core.sv */
`default_nettype none

// RGB to HSV color classifier. Each accepted word (red, green, blue levels) yields one result
// word carrying hue in degrees, saturation (max minus min), value (max) and a color code of
// none, black, white, red, yellow, green or blue; when no class matches, the previous color
// code is repeated, and it starts as none after reset. One item is in work at a time: a setup
// state finds max, min and the scaled hue numerator, six steps of a restoring divider produce
// one quotient bit per cycle, and a finish state forms the hue and the class and loads the
// output register. A new word is taken only in the idle state, after the last one has left
// the finish state. The result sits in an output register, so the next word is accepted while
// it waits; a result still waiting holds the following one in its finish state. Control
// registers are written through csr_we, csr_index and csr_wdata; writes to an index above 7
// are dropped, and writes are only meant while idle.
module rgb_hsv_color_classifier_core
   import rhcc_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [CHANNEL_BITS-1:0]     req_red_level,
   input  wire  [CHANNEL_BITS-1:0]     req_green_level,
   input  wire  [CHANNEL_BITS-1:0]     req_blue_level,

   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [CODE_BITS-1:0]        rsp_color_code,
   output logic [HUE_BITS-1:0]         rsp_hue_deg,
   output logic [FIELD_BITS-1:0]       rsp_saturation,
   output logic [FIELD_BITS-1:0]       rsp_brightness_value,

   input  wire                         csr_we,
   input  wire  [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [CSR_DATA_BITS-1:0]    csr_wdata
);

   // Control registers
   logic [HUE_BITS-1:0]   hue_red_yellow_ff;
   logic [HUE_BITS-1:0]   hue_yellow_green_ff;
   logic [HUE_BITS-1:0]   hue_green_blue_ff;
   logic [HUE_BITS-1:0]   hue_blue_red_ff;
   logic [FIELD_BITS-1:0] min_sat_chromatic_ff;
   logic [FIELD_BITS-1:0] min_sat_yellow_ff;
   logic [FIELD_BITS-1:0] gray_sat_limit_ff;
   logic [FIELD_BITS-1:0] black_white_split_ff;

   // Control state
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   color_code_type        last_color_ff, last_color_in;

   // Datapath
   logic [CHANNEL_BITS-1:0] red_ff, red_in;
   logic [CHANNEL_BITS-1:0] green_ff, green_in;
   logic [CHANNEL_BITS-1:0] blue_ff, blue_in;
   logic [CHANNEL_BITS-1:0] max_ff, max_in;
   logic [CHANNEL_BITS-1:0] dvs_ff, dvs_in;
   max_sel_type             sel_ff, sel_in;
   logic                    neg_ff, neg_in;
   logic [CHANNEL_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0]     num_ff, num_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [HUE_BITS-1:0]     rsp_hue_ff, rsp_hue_in;
   logic [FIELD_BITS-1:0]   rsp_sat_ff, rsp_sat_in;
   logic [FIELD_BITS-1:0]   rsp_val_ff, rsp_val_in;

   // Setup signals
   logic                    blue_max;
   logic                    green_max;
   logic [CHANNEL_BITS-1:0] mx;
   logic [CHANNEL_BITS-1:0] mn;
   logic [CHANNEL_BITS-1:0] op_a;
   logic [CHANNEL_BITS-1:0] op_b;
   logic [CHANNEL_BITS-1:0] mag;
   logic [NUM_BITS-1:0]     mag_ext;
   logic [NUM_BITS-1:0]     numer;

   // Divider step signals
   logic [CHANNEL_BITS:0]   shifted;
   logic [CHANNEL_BITS:0]   trial;
   logic                    fits;

   // Finish signals
   logic [HUE_EXT_BITS-1:0] quo_ext;
   logic [HUE_EXT_BITS-1:0] hue_ext;
   logic [HUE_BITS-1:0]     hue;
   logic [CMP_BITS-1:0]     sat_cmp;
   logic [CMP_BITS-1:0]     val_cmp;
   logic                    gray;
   logic                    chroma_ok;
   logic                    yellow_ok;
   color_code_type          color_new;

   logic                    accept;
   logic                    load_rsp;

   assign accept   = req_valid && req_ready;
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Hold control registers, update on write
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_red_yellow_ff    <= RST_HUE_RED_YELLOW;
         hue_yellow_green_ff  <= RST_HUE_YELLOW_GREEN;
         hue_green_blue_ff    <= RST_HUE_GREEN_BLUE;
         hue_blue_red_ff      <= RST_HUE_BLUE_RED;
         min_sat_chromatic_ff <= RST_MIN_SAT_CHROMATIC;
         min_sat_yellow_ff    <= RST_MIN_SAT_YELLOW;
         gray_sat_limit_ff    <= RST_GRAY_SAT_LIMIT;
         black_white_split_ff <= RST_BLACK_WHITE_SPLIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HUE_RED_YELLOW:    hue_red_yellow_ff    <= csr_wdata[HUE_BITS-1:0];
            CSR_HUE_YELLOW_GREEN:  hue_yellow_green_ff  <= csr_wdata[HUE_BITS-1:0];
            CSR_HUE_GREEN_BLUE:    hue_green_blue_ff    <= csr_wdata[HUE_BITS-1:0];
            CSR_HUE_BLUE_RED:      hue_blue_red_ff      <= csr_wdata[HUE_BITS-1:0];
            CSR_MIN_SAT_CHROMATIC: min_sat_chromatic_ff <= csr_wdata[FIELD_BITS-1:0];
            CSR_MIN_SAT_YELLOW:    min_sat_yellow_ff    <= csr_wdata[FIELD_BITS-1:0];
            CSR_GRAY_SAT_LIMIT:    gray_sat_limit_ff    <= csr_wdata[FIELD_BITS-1:0];
            CSR_BLACK_WHITE_SPLIT: black_white_split_ff <= csr_wdata[FIELD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         last_color_ff <= CLS_NONE;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_color_ff <= last_color_in;
      end
   end

   // Next state, handshake and step count
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Find max, min and the scaled numerator of the hue quotient
   always_comb begin
      blue_max  = (blue_ff >= red_ff) && (blue_ff >= green_ff);
      green_max = (green_ff >= red_ff) && (green_ff >= blue_ff);

      mn = red_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn) mn = blue_ff;

      if (blue_max) begin
         sel_in = SEL_BLUE;
         mx     = blue_ff;
         op_a   = red_ff;
         op_b   = green_ff;
      end else if (green_max) begin
         sel_in = SEL_GREEN;
         mx     = green_ff;
         op_a   = blue_ff;
         op_b   = red_ff;
      end else begin
         sel_in = SEL_RED;
         mx     = red_ff;
         op_a   = green_ff;
         op_b   = blue_ff;
      end

      neg_in  = op_a < op_b;
      mag     = neg_in ? (op_b - op_a) : (op_a - op_b);
      mag_ext = NUM_BITS'(mag);
      // times 60 as times 64 minus times 4
      numer   = (mag_ext << 6) - (mag_ext << 2);
   end

   // One restoring divider step
   always_comb begin
      shifted = {rem_ff, num_ff[QUO_BITS-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
   end

   // Form hue and classify
   always_comb begin
      quo_ext = HUE_EXT_BITS'(quo_ff);
      case (sel_ff)
         SEL_GREEN: hue_ext = neg_ff ? (HUE_GREEN_BASE - quo_ext) : (HUE_GREEN_BASE + quo_ext);
         SEL_BLUE:  hue_ext = neg_ff ? (HUE_BLUE_BASE - quo_ext) : (HUE_BLUE_BASE + quo_ext);
         default: begin
            if (neg_ff && (quo_ff != '0)) begin
               hue_ext = HUE_FULL_TURN - quo_ext;
            end else begin
               hue_ext = quo_ext;
            end
         end
      endcase
      hue = (dvs_ff == '0) ? '0 : hue_ext[HUE_BITS-1:0];

      sat_cmp   = CMP_BITS'(dvs_ff);
      val_cmp   = CMP_BITS'(max_ff);
      gray      = sat_cmp < CMP_BITS'(gray_sat_limit_ff);
      chroma_ok = sat_cmp >= CMP_BITS'(min_sat_chromatic_ff);
      yellow_ok = sat_cmp >= CMP_BITS'(min_sat_yellow_ff);

      // White, black, green, yellow, blue, red; otherwise keep the last color
      if (gray && (val_cmp > CMP_BITS'(black_white_split_ff))) begin
         color_new = CLS_WHITE;
      end else if (gray) begin
         color_new = CLS_BLACK;
      end else if ((hue >= hue_yellow_green_ff) && (hue < hue_green_blue_ff) && chroma_ok) begin
         color_new = CLS_GREEN;
      end else if ((hue >= hue_red_yellow_ff) && (hue < hue_yellow_green_ff) && yellow_ok) begin
         color_new = CLS_YELLOW;
      end else if ((hue >= hue_green_blue_ff) && (hue < hue_blue_red_ff) && chroma_ok) begin
         color_new = CLS_BLUE;
      end else if (((hue < hue_red_yellow_ff) || (hue >= hue_blue_red_ff)) && chroma_ok) begin
         color_new = CLS_RED;
      end else begin
         color_new = last_color_ff;
      end
   end

   // Datapath next values
   always_comb begin
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      max_in        = max_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      rsp_hue_in    = rsp_hue_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_val_in    = rsp_val_ff;
      last_color_in = last_color_ff;

      // Capture the sample
      if (accept) begin
         red_in   = req_red_level;
         green_in = req_green_level;
         blue_in  = req_blue_level;
      end

      // Load the divider; the quotient is below 64, so the top bits start as remainder
      if (state_ff == ST_SETUP) begin
         max_in = mx;
         dvs_in = mx - mn;
         rem_in = numer[NUM_BITS-1:QUO_BITS];
         num_in = numer[QUO_BITS-1:0];
         quo_in = '0;
      end

      // Shift in one numerator bit, emit one quotient bit
      if (state_ff == ST_DIV) begin
         rem_in = fits ? trial[CHANNEL_BITS-1:0] : shifted[CHANNEL_BITS-1:0];
         num_in = {num_ff[QUO_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
      end

      // Drive the output register
      if (load_rsp) begin
         rsp_hue_in    = hue;
         rsp_sat_in    = sat_cmp[FIELD_BITS-1:0];
         rsp_val_in    = val_cmp[FIELD_BITS-1:0];
         last_color_in = color_new;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
      max_ff     <= max_in;
      dvs_ff     <= dvs_in;
      sel_ff     <= sel_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      rsp_hue_ff <= rsp_hue_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_color_code       = last_color_ff;
   assign rsp_hue_deg          = rsp_hue_ff;
   assign rsp_saturation       = rsp_sat_ff;
   assign rsp_brightness_value = rsp_val_ff;

   // An accepted word always starts the setup cycle
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SETUP))
      else $error("accepted word did not enter setup");

   // The divider moves to finish after its sixth and last step
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (cnt_ff == DIV_LAST)) |=> (state_ff == ST_FINISH))
      else $error("divider did not finish after its last step");

   // A new result only appears out of the finish cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   // Hue stays inside one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hue_ff < HUE_FULL_TURN[HUE_BITS-1:0]))
      else $error("hue out of range");

endmodule

`default_nettype wire

/* bench/tb_rgb_hsv_color_classifier_core.sv */
`timescale 1ns / 100ps

module tb_rgb_hsv_color_classifier_core
   import rhcc_pkg::*;
();

   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 115;
   localparam int MAX_REPORTS   = 10;
   localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;

   // Hue sector geometry
   localparam int DEG_SECTOR = 60;
   localparam int DEG_TURN   = 360;
   localparam int DEG_GREEN  = 120;
   localparam int DEG_BLUE   = 240;

   // Lowest register index that maps to nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 4'd8;

   typedef struct packed {
      color_code_type            code;
      logic [HUE_BITS-1:0]       hue;
      logic [FIELD_BITS-1:0]     sat;
      logic [FIELD_BITS-1:0]     val;
   } hsv_word_type;

   typedef enum logic [1:0] {
      ROW_SAMPLE = 2'd0,
      ROW_WRITE  = 2'd1
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [CHANNEL_BITS-1:0]   red;
      logic [CHANNEL_BITS-1:0]   green;
      logic [CHANNEL_BITS-1:0]   blue;
      logic                      typed;
      hsv_word_type              want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_ready;
   logic [CHANNEL_BITS-1:0]   req_red_level;
   logic [CHANNEL_BITS-1:0]   req_green_level;
   logic [CHANNEL_BITS-1:0]   req_blue_level;

   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [CODE_BITS-1:0]      rsp_color_code;
   logic [HUE_BITS-1:0]       rsp_hue_deg;
   logic [FIELD_BITS-1:0]     rsp_saturation;
   logic [FIELD_BITS-1:0]     rsp_brightness_value;

   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Classifier thresholds as the block should hold them
   logic [HUE_BITS-1:0]   hue_ry, hue_yg, hue_gb, hue_br;
   logic [FIELD_BITS-1:0] sat_chroma, sat_yellow, sat_gray, val_split;
   color_code_type        last_code;

   hsv_word_type results_due[$];
   stim_row_type directed_rows[$];

   int  cycle_count     = 0;
   int  mismatch_count  = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  long_holds      = 0;
   logic hold_request;

   rgb_hsv_color_classifier_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_red_level        (req_red_level),
      .req_green_level      (req_green_level),
      .req_blue_level       (req_blue_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_color_code       (rsp_color_code),
      .rsp_hue_deg          (rsp_hue_deg),
      .rsp_saturation       (rsp_saturation),
      .rsp_brightness_value (rsp_brightness_value),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Compute hue, saturation and value of one sample and advance the color state
   function automatic hsv_word_type predict_color(input logic [CHANNEL_BITS-1:0] r,
                                                  input logic [CHANNEL_BITS-1:0] g,
                                                  input logic [CHANNEL_BITS-1:0] b);
      int           ri, gi, bi, mx, mn, span, deg;
      max_sel_type  sel;
      hsv_word_type res;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      mn = ri;
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      // Ties for the maximum go to blue, then green
      mx  = ri;
      sel = SEL_RED;
      if (gi >= ri && gi >= bi) begin
         mx  = gi;
         sel = SEL_GREEN;
      end
      if (bi >= ri && bi >= gi) begin
         mx  = bi;
         sel = SEL_BLUE;
      end
      span = mx - mn;
      deg  = 0;
      // Integer division truncates toward zero, like the block's divide of the magnitude with the sign applied after
      if (span > 0) begin
         case (sel)
            SEL_RED:   deg = (DEG_SECTOR * (gi - bi) / span + DEG_TURN) % DEG_TURN;
            SEL_GREEN: deg = DEG_SECTOR * (bi - ri) / span + DEG_GREEN;
            default:   deg = DEG_SECTOR * (ri - gi) / span + DEG_BLUE;
         endcase
      end
      res.hue = deg[HUE_BITS-1:0];
      res.sat = span[FIELD_BITS-1:0];
      res.val = mx[FIELD_BITS-1:0];
      // Classify by priority; keep the previous color when nothing matches
      if (res.val > val_split && res.sat < sat_gray)
         last_code = CLS_WHITE;
      else if (res.val <= val_split && res.sat < sat_gray)
         last_code = CLS_BLACK;
      else if (res.hue >= hue_yg && res.hue < hue_gb && res.sat >= sat_chroma)
         last_code = CLS_GREEN;
      else if (res.hue >= hue_ry && res.hue < hue_yg && res.sat >= sat_yellow)
         last_code = CLS_YELLOW;
      else if (res.hue >= hue_gb && res.hue < hue_br && res.sat >= sat_chroma)
         last_code = CLS_BLUE;
      else if ((res.hue < hue_ry || res.hue >= hue_br) && res.sat >= sat_chroma)
         last_code = CLS_RED;
      res.code = last_code;
      return res;
   endfunction

   function automatic stim_row_type item_row(input int r, input int g, input int b);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_SAMPLE;
      row.red   = CHANNEL_BITS'(r);
      row.green = CHANNEL_BITS'(g);
      row.blue  = CHANNEL_BITS'(b);
      return row;
   endfunction

   function automatic stim_row_type typed_row(input int r, input int g, input int b,
                                              input color_code_type c,
                                              input int h, input int s, input int v);
      stim_row_type row;
      row           = item_row(r, g, b);
      row.typed     = 1'b1;
      row.want.code = c;
      row.want.hue  = HUE_BITS'(h);
      row.want.sat  = FIELD_BITS'(s);
      row.want.val  = FIELD_BITS'(v);
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                            input int data);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.index = idx;
      row.data  = CSR_DATA_BITS'(data);
      return row;
   endfunction

   function automatic void report_mismatch(input string why, input hsv_word_type want,
                                           input hsv_word_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch (%s): expected code %0d hue %0d sat %0d val %0d, ",
                  $time, why, want.code, want.hue, want.sat, want.val,
                  "got code %0d hue %0d sat %0d val %0d",
                  got.code, got.hue, got.sat, got.val);
   endfunction

   // Offer one word, hold it until accepted, then record the expected result
   task automatic send_word(input logic [CHANNEL_BITS-1:0] r,
                            input logic [CHANNEL_BITS-1:0] g,
                            input logic [CHANNEL_BITS-1:0] b,
                            input logic typed, input hsv_word_type given);
      hsv_word_type predicted;
      req_valid       <= 1'b1;
      req_red_level   <= r;
      req_green_level <= g;
      req_blue_level  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      predicted = predict_color(r, g, b);
      results_due.push_back(typed ? given : predicted);
   endtask

   // Drop valid and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_HUE_RED_YELLOW:    hue_ry     = data[HUE_BITS-1:0];
         CSR_HUE_YELLOW_GREEN:  hue_yg     = data[HUE_BITS-1:0];
         CSR_HUE_GREEN_BLUE:    hue_gb     = data[HUE_BITS-1:0];
         CSR_HUE_BLUE_RED:      hue_br     = data[HUE_BITS-1:0];
         CSR_MIN_SAT_CHROMATIC: sat_chroma = data;
         CSR_MIN_SAT_YELLOW:    sat_yellow = data;
         CSR_GRAY_SAT_LIMIT:    sat_gray   = data;
         CSR_BLACK_WHITE_SPLIT: val_split  = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Check each accepted result word against the oldest expectation
   always @(posedge clock) begin
      hsv_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.code = color_code_type'(rsp_color_code);
         got.hue  = rsp_hue_deg;
         got.sat  = rsp_saturation;
         got.val  = rsp_brightness_value;
         if (results_due.size() == 0)
            report_mismatch("unexpected result", '0, got);
         else if (results_due[0] !== got)
            report_mismatch("wrong field", results_due.pop_front(), got);
         else
            void'(results_due.pop_front());
         results_checked++;
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: stall in epochs of varying style, plus one long hold on request
   initial begin
      int         mode, epoch_left, hold_left, tick;
      logic [7:0] pattern;
      rsp_ready    = 1'b0;
      hold_request = 1'b0;
      mode         = 0;
      epoch_left   = 0;
      hold_left    = 0;
      tick         = 0;
      pattern      = '1;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            long_holds++;
         end
         if (epoch_left == 0) begin
            mode       = $urandom_range(0, 3);
            epoch_left = $urandom_range(16, 96);
            pattern    = 8'($urandom | 8'h01);
         end
         epoch_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= pattern[tick % 8];
            endcase
         end
      end
   end

   // Stimulus
   initial begin
      stim_row_type            row;
      int                      phase, n, burst_left, gap, base, v1, v2;
      int                      ry, yg, gb, br, chroma, yellow, gray, split;
      logic [CHANNEL_BITS-1:0] r, g, b;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_red_level   = '0;
      req_green_level = '0;
      req_blue_level  = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      hue_ry          = RST_HUE_RED_YELLOW;
      hue_yg          = RST_HUE_YELLOW_GREEN;
      hue_gb          = RST_HUE_GREEN_BLUE;
      hue_br          = RST_HUE_BLUE_RED;
      sat_chroma      = RST_MIN_SAT_CHROMATIC;
      sat_yellow      = RST_MIN_SAT_YELLOW;
      sat_gray        = RST_GRAY_SAT_LIMIT;
      val_split       = RST_BLACK_WHITE_SPLIT;
      last_code       = CLS_NONE;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners at reset thresholds, band edges, ignored index, kept color
      directed_rows = '{
         typed_row(0, 0, 0, CLS_BLACK, 0, 0, 0),
         typed_row(1023, 1023, 1023, CLS_WHITE, 0, 0, 1023),
         typed_row(1023, 0, 0, CLS_RED, 0, 1023, 1023),
         typed_row(0, 1023, 0, CLS_GREEN, 120, 1023, 1023),
         typed_row(0, 0, 1023, CLS_BLUE, 240, 1023, 1023),
         typed_row(1023, 1023, 0, CLS_YELLOW, 60, 1023, 1023),
         typed_row(1023, 0, 1023, CLS_RED, 300, 1023, 1023),
         typed_row(0, 1023, 1023, CLS_BLUE, 180, 1023, 1023),
         typed_row(5, 5, 5, CLS_BLACK, 0, 0, 5),
         typed_row(200, 200, 200, CLS_WHITE, 0, 0, 200),
         item_row(100, 0, 1),
         item_row(100, 0, 50),
         item_row(100, 100, 60),
         item_row(101, 101, 60),
         item_row(150, 100, 100),
         item_row(200, 100, 0),
         item_row(200, 400, 0),
         item_row(0, 400, 200),
         item_row(200, 0, 400),
         csr_row(CSR_UNMAPPED, 0),
         item_row(1023, 0, 10),
         csr_row(CSR_MIN_SAT_CHROMATIC, 1023),
         csr_row(CSR_MIN_SAT_YELLOW, 1023),
         csr_row(CSR_GRAY_SAT_LIMIT, 0),
         item_row(1000, 0, 0),
         item_row(0, 500, 0)
      };
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            csr_write(row.index, row.data);
         end else begin
            send_word(row.red, row.green, row.blue, row.typed, row.want);
         end
      end

      // Random phases, each under its own threshold set
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            ry = int'(RST_HUE_RED_YELLOW);      yg = int'(RST_HUE_YELLOW_GREEN);
            gb = int'(RST_HUE_GREEN_BLUE);      br = int'(RST_HUE_BLUE_RED);
            chroma = int'(RST_MIN_SAT_CHROMATIC); yellow = int'(RST_MIN_SAT_YELLOW);
            gray = int'(RST_GRAY_SAT_LIMIT);    split = int'(RST_BLACK_WHITE_SPLIT);
         end else if (phase == 1) begin
            ry = 0; yg = 0; gb = 0; br = 0;
            chroma = 0; yellow = 0; gray = 0; split = 0;
         end else if (phase == 2) begin
            ry = CHAN_MAX; yg = CHAN_MAX; gb = CHAN_MAX; br = CHAN_MAX;
            chroma = CHAN_MAX; yellow = CHAN_MAX; gray = CHAN_MAX; split = CHAN_MAX;
         end else if (phase == PHASES - 1) begin
            // Unordered and out-of-range thresholds
            ry = $urandom_range(0, CHAN_MAX); yg = $urandom_range(0, CHAN_MAX);
            gb = $urandom_range(0, CHAN_MAX); br = $urandom_range(0, CHAN_MAX);
            chroma = $urandom_range(0, CHAN_MAX); yellow = $urandom_range(0, CHAN_MAX);
            gray = $urandom_range(0, CHAN_MAX);   split = $urandom_range(0, CHAN_MAX);
         end else begin
            // Ordered bands over a full turn
            ry = $urandom_range(0, 120);
            yg = ry + $urandom_range(0, 120);
            gb = yg + $urandom_range(0, 120);
            br = gb + $urandom_range(0, DEG_TURN - gb);
            chroma = $urandom_range(0, 300); yellow = $urandom_range(0, 300);
            gray = $urandom_range(0, 300);   split = $urandom_range(0, CHAN_MAX);
         end
         wait_idle();
         if (phase >= 3)
            csr_write(CSR_INDEX_BITS'($urandom_range(CSR_UNMAPPED, 15)),
                      CSR_DATA_BITS'($urandom_range(0, CHAN_MAX)));
         csr_write(CSR_HUE_RED_YELLOW,    CSR_DATA_BITS'(ry));
         csr_write(CSR_HUE_YELLOW_GREEN,  CSR_DATA_BITS'(yg));
         csr_write(CSR_HUE_GREEN_BLUE,    CSR_DATA_BITS'(gb));
         csr_write(CSR_HUE_BLUE_RED,      CSR_DATA_BITS'(br));
         csr_write(CSR_MIN_SAT_CHROMATIC, CSR_DATA_BITS'(chroma));
         csr_write(CSR_MIN_SAT_YELLOW,    CSR_DATA_BITS'(yellow));
         csr_write(CSR_GRAY_SAT_LIMIT,    CSR_DATA_BITS'(gray));
         csr_write(CSR_BLACK_WHITE_SPLIT, CSR_DATA_BITS'(split));

         burst_left = $urandom_range(1, 24);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Mix sample shapes: uniform, dark, near gray, two tied channels, rails
            case ($urandom_range(0, 5))
               0, 1: begin
                  r = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
                  g = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
                  b = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
               end
               2: begin
                  r = CHANNEL_BITS'($urandom_range(0, 127));
                  g = CHANNEL_BITS'($urandom_range(0, 127));
                  b = CHANNEL_BITS'($urandom_range(0, 127));
               end
               3: begin
                  base = $urandom_range(0, CHAN_MAX);
                  r = CHANNEL_BITS'((base > CHAN_MAX - 60) ? base - $urandom_range(0, 60)
                                                           : base + $urandom_range(0, 60));
                  g = CHANNEL_BITS'((base > CHAN_MAX - 60) ? base - $urandom_range(0, 60)
                                                           : base + $urandom_range(0, 60));
                  b = CHANNEL_BITS'((base > CHAN_MAX - 60) ? base - $urandom_range(0, 60)
                                                           : base + $urandom_range(0, 60));
               end
               4: begin
                  v1 = $urandom_range(0, CHAN_MAX);
                  v2 = $urandom_range(0, CHAN_MAX);
                  case ($urandom_range(0, 2))
                     0: begin
                        r = CHANNEL_BITS'(v1); g = CHANNEL_BITS'(v1); b = CHANNEL_BITS'(v2);
                     end
                     1: begin
                        r = CHANNEL_BITS'(v1); g = CHANNEL_BITS'(v2); b = CHANNEL_BITS'(v1);
                     end
                     default: begin
                        r = CHANNEL_BITS'(v2); g = CHANNEL_BITS'(v1); b = CHANNEL_BITS'(v1);
                     end
                  endcase
               end
               default: begin
                  r = CHANNEL_BITS'($urandom_range(0, 1) ? ($urandom_range(0, 1) ? CHAN_MAX : 0)
                                                         : $urandom_range(0, CHAN_MAX));
                  g = CHANNEL_BITS'($urandom_range(0, 1) ? ($urandom_range(0, 1) ? CHAN_MAX : 0)
                                                         : $urandom_range(0, CHAN_MAX));
                  b = CHANNEL_BITS'($urandom_range(0, 1) ? ($urandom_range(0, 1) ? CHAN_MAX : 0)
                                                         : $urandom_range(0, CHAN_MAX));
               end
            endcase

            // Back up the output while words keep coming
            if (phase == 4 && n == 40)
               hold_request = 1'b1;
            // Pause the sender until the pipe is empty
            if (phase == 6 && n == 60)
               wait_idle();

            send_word(r, g, b, 1'b0, '0);

            // Advance bursts; gaps between them
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      wait_idle();
      while (results_due.size() != 0)
         report_mismatch("result never arrived", results_due.pop_front(), '0);

      $display("checked %0d results from %0d samples under %0d threshold settings",
               results_checked, items_sent, PHASES + 1);
      $display("%0d long output stall(s), %0d mismatch(es)", long_holds, mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
design/rhcc_pkg.sv
design/rgb_hsv_color_classifier_core.sv
bench/tb_rgb_hsv_color_classifier_core.sv
